[rtl/core/assert_macros.svh]
// Assertion macros used by the port-level checker.
// Depends on nothing; include once per compilation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication, disabled while the active-low reset is low.
`define ATA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define ATA_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[rtl/core/ata_pkg.sv]
// Package for the tilt angle unit: payload structs, CORDIC constants.
// Depends on nothing.
package ata_pkg;
  localparam int unsigned StatusW  = 8;
  localparam int unsigned FieldW   = 16;
  localparam int unsigned Steps    = 23;
  localparam int unsigned StepW    = 5;
  localparam int unsigned AccFrac  = 16;
  localparam int unsigned Prescale = 7;
  localparam int unsigned AngW     = 24;
  localparam logic [StatusW-1:0] FreshMask = 8'h03;

  typedef struct packed {
    logic [7:0]         status;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } ata_in_t;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [15:0] held_gyro_x;
    logic signed [15:0] held_gyro_y;
    logic signed [15:0] held_gyro_z;
    logic               fresh;
    logic [2:0]         undefined_axes;
  } ata_out_t;

  typedef struct packed {
    logic start;
    logic step;
  } ata_ctl_t;

  function automatic logic [AngW-1:0] atan_tab(input logic [StepW-1:0] i);
    logic [AngW-1:0] v;
    unique case (i)
      5'd0:  v = 24'd2949120;
      5'd1:  v = 24'd1740967;
      5'd2:  v = 24'd919879;
      5'd3:  v = 24'd466945;
      5'd4:  v = 24'd234379;
      5'd5:  v = 24'd117304;
      5'd6:  v = 24'd58666;
      5'd7:  v = 24'd29335;
      5'd8:  v = 24'd14668;
      5'd9:  v = 24'd7334;
      5'd10: v = 24'd3667;
      5'd11: v = 24'd1833;
      5'd12: v = 24'd917;
      5'd13: v = 24'd458;
      5'd14: v = 24'd229;
      5'd15: v = 24'd115;
      5'd16: v = 24'd57;
      5'd17: v = 24'd29;
      5'd18: v = 24'd14;
      5'd19: v = 24'd7;
      5'd20: v = 24'd4;
      5'd21: v = 24'd2;
      5'd22: v = 24'd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

[rtl/core/ata_isqrt.sv]
// Bit-serial integer square root, one result bit (two radicand bits) a cycle.
// Depends on ata_pkg.
module ata_isqrt
  import ata_pkg::*;
#(
  parameter int unsigned IN_W = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [IN_W-1:0]     radicand,
  output logic                done,
  output logic [IN_W/2-1:0]   root
);
  localparam int unsigned RW = IN_W / 2;
  localparam int unsigned CW = $clog2(RW + 1);

  logic [IN_W-1:0] rem_r, rem_nxt, rad_r, rad_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [IN_W-1:0] trial, shifted;

  // Restoring method: bring down two radicand bits, try 4r+1.
  always_comb begin
    shifted  = {rem_r[IN_W-3:0], rad_r[IN_W-1 -: 2]};
    trial    = IN_W'({root_r, 2'b01});
    rem_nxt  = rem_r;
    rad_nxt  = rad_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      rad_nxt  = radicand;
      root_nxt = '0;
      cnt_nxt  = CW'(RW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[IN_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt  = shifted - trial;
        root_nxt = {root_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        root_nxt = {root_r[RW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
  end

  assign done = busy_r && (cnt_r == CW'(1));
  assign root = root_nxt;
endmodule

[rtl/core/ata_cordic_lane.sv]
// One CORDIC vectoring lane: atan(n/d) in degrees, one step a cycle while ctl.step is high.
// Depends on ata_pkg.
module ata_cordic_lane
  import ata_pkg::*;
#(
  parameter int unsigned VW = 26,
  parameter int unsigned FRAC = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ata_ctl_t             ctl,
  input  logic [StepW-1:0]     step_idx,
  input  logic signed [VW-1:0] num,
  input  logic signed [VW-1:0] den,
  output logic [15:0]          angle,
  output logic                 undef
);
  localparam int unsigned XW = VW + 2;

  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [AngW:0] z_r, z_nxt;
  logic                 neg_r, zd_r, zn_r, nneg_r;
  logic signed [XW-1:0] ys, xs;
  logic signed [AngW:0] zc;
  logic [AngW:0]        zr;
  logic signed [AngW+1:0] res;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    ys = y_r >>> step_idx;
    xs = x_r >>> step_idx;
    if (ctl.start) begin
      x_nxt = den[VW-1] ? -XW'(den) : XW'(den);
      y_nxt = num[VW-1] ? -XW'(num) : XW'(num);
      z_nxt = '0;
    end else if (ctl.step) begin
      if (!y_r[XW-1]) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + $signed({1'b0, atan_tab(step_idx)});
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - $signed({1'b0, atan_tab(step_idx)});
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    if (ctl.start) begin
      neg_r  <= (num[VW-1] != den[VW-1]) && (num != '0);
      nneg_r <= num[VW-1];
      zd_r   <= (den == '0);
      zn_r   <= (num == '0);
    end
  end

  // Clamp to the first quadrant, round to the output fraction, apply sign; d=0: +-90 or 0.
  always_comb begin
    zc = z_r;
    if (z_r < 0) zc = '0;
    if (z_r > $signed((AngW+1)'(90 << AccFrac))) zc = $signed((AngW+1)'(90 << AccFrac));
    if (AccFrac > FRAC) zr = (AngW+1)'(($unsigned(zc) + ((AngW+1)'(1) << (AccFrac - FRAC - 1)))
                              >> (AccFrac - FRAC));
    else zr = $unsigned(zc);
    if (zd_r) begin
      if (zn_r) res = '0;
      else res = nneg_r ? -$signed((AngW+2)'(90 << FRAC)) : $signed((AngW+2)'(90 << FRAC));
    end else begin
      res = neg_r ? -$signed({1'b0, zr}) : $signed({1'b0, zr});
    end
  end

  assign angle = res[15:0];
  assign undef = zd_r && zn_r;
  logic unused_rst;
  assign unused_rst = rst_n;
endmodule

[rtl/core/accel_tilt_angle_unit.sv]
// Top level of the tilt angle unit: hold registers, square roots, three
// CORDIC lanes and the result merge. Depends on ata_pkg and its submodules.
//
// Usage: in_valid/in_ready/in_data accept one beat of status and six samples.
// When status bits 1:0 are nonzero the samples are latched, otherwise the held
// samples are reused. One result beat appears on out_valid/out_data per input.
// From the accepting edge to out_valid: go_r starts the roots, the bit-serial
// square roots run (two radicand bits a cycle), cstart_r loads the lanes,
// 23 CORDIC steps set by the shared step counter drive all three lanes in
// parallel, and the result enters the output register.
// One item is processed at a time; in_ready rises again as soon as the result
// sits in the output register, so the next beat is taken while that result
// waits. A stalled receiver holds out_data steady and, once the next item has
// finished, holds in_ready low.
// Reset (rst_n low, synchronous) clears the held samples to zero and empties
// the pipeline; no output beat is pending afterwards.
module accel_tilt_angle_unit
  import ata_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ata_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ata_out_t out_data
);
  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned SQW = 2 * SW + 2 * Prescale + 2;
  localparam int unsigned RW = SQW / 2;
  localparam int unsigned VW = RW + 2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SQRT = 4'b0010, S_CORD = 4'b0100, S_DONE = 4'b1000
  } st_t;

  st_t st_r, st_nxt;
  logic signed [SW-1:0] ax_r, ay_r, az_r, gx_r, gy_r, gz_r;
  logic [StepW-1:0] step_r, step_nxt;
  logic out_valid_r;
  ata_out_t out_r;
  logic in_acc, sq_done;
  logic [SQW-1:0] rad_yz, rad_xz, rad_xy;
  logic [RW-1:0] rt_yz, rt_xz, rt_xy, rt_xz_u, rt_xy_u;
  logic d1, d2;
  ata_ctl_t ctl;
  logic [15:0] ang0, ang1, ang2;
  logic u0, u1, u2;

  function automatic logic [SQW-1:0] sqsum(input logic signed [SW-1:0] a,
                                           input logic signed [SW-1:0] b);
    logic signed [2*SW-1:0] pa, pb;
    pa = a * a;
    pb = b * b;
    return (SQW'($unsigned(pa)) + SQW'($unsigned(pb))) << (2 * Prescale);
  endfunction

  assign rad_yz = sqsum(ay_r, az_r);
  assign rad_xz = sqsum(ax_r, az_r);
  assign rad_xy = sqsum(ax_r, ay_r);

  assign in_ready = (st_r == S_IDLE);
  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0; ay_r <= '0; az_r <= '0;
      gx_r <= '0; gy_r <= '0; gz_r <= '0;
    end else if (in_acc) begin
      if ((in_data.status & FreshMask) != '0) begin
        ax_r <= in_data.acc_x[SW-1:0];
        ay_r <= in_data.acc_y[SW-1:0];
        az_r <= in_data.acc_z[SW-1:0];
        gx_r <= in_data.gyro_x[SW-1:0];
        gy_r <= in_data.gyro_y[SW-1:0];
        gz_r <= in_data.gyro_z[SW-1:0];
      end
    end
  end

  // The fresh flag of the item travels beside the computation.
  logic item_fresh_r;
  logic go_r;
  always_ff @(posedge clk) begin
    if (!rst_n) go_r <= 1'b0;
    else go_r <= in_acc;
    if (in_acc) item_fresh_r <= (in_data.status & FreshMask) != '0;
  end

  ata_isqrt #(.IN_W(SQW)) u_sq0 (.clk, .rst_n, .start(go_r), .radicand(rad_yz),
    .done(sq_done), .root(rt_yz));
  ata_isqrt #(.IN_W(SQW)) u_sq1 (.clk, .rst_n, .start(go_r), .radicand(rad_xz),
    .done(d1), .root(rt_xz_u));
  ata_isqrt #(.IN_W(SQW)) u_sq2 (.clk, .rst_n, .start(go_r), .radicand(rad_xy),
    .done(d2), .root(rt_xy_u));
  assign rt_xz = rt_xz_u;
  assign rt_xy = rt_xy_u;

  logic [RW-1:0] r0_r, r1_r, r2_r;
  always_ff @(posedge clk) begin
    if (sq_done) begin
      r0_r <= rt_yz;
      r1_r <= rt_xz;
      r2_r <= rt_xy;
    end
  end

  logic cstart_r;
  always_ff @(posedge clk) begin
    if (!rst_n) cstart_r <= 1'b0;
    else cstart_r <= sq_done;
  end

  always_comb begin
    st_nxt = st_r;
    step_nxt = step_r;
    unique case (st_r)
      S_IDLE: if (in_acc) st_nxt = S_SQRT;
      S_SQRT: if (cstart_r) begin st_nxt = S_CORD; step_nxt = '0; end
      S_CORD: begin
        step_nxt = step_r + 1'b1;
        if (step_r == StepW'(Steps - 1)) st_nxt = S_DONE;
      end
      S_DONE: if (!out_valid_r || out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign ctl.start = cstart_r;
  assign ctl.step = (st_r == S_CORD);

  localparam logic [Prescale-1:0] PZ = '0;
  ata_cordic_lane #(.VW(VW), .FRAC(ANGLE_FRAC_BITS)) u_l0 (.clk, .rst_n, .ctl,
    .step_idx(step_r), .num(VW'($signed({ax_r, PZ}))), .den($signed({2'b00, r0_r})),
    .angle(ang0), .undef(u0));
  ata_cordic_lane #(.VW(VW), .FRAC(ANGLE_FRAC_BITS)) u_l1 (.clk, .rst_n, .ctl,
    .step_idx(step_r), .num(VW'($signed({ay_r, PZ}))), .den($signed({2'b00, r1_r})),
    .angle(ang1), .undef(u1));
  ata_cordic_lane #(.VW(VW), .FRAC(ANGLE_FRAC_BITS)) u_l2 (.clk, .rst_n, .ctl,
    .step_idx(step_r), .num($signed({2'b00, r2_r})), .den(VW'($signed({az_r, PZ}))),
    .angle(ang2), .undef(u2));

  // Merge the three lanes into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (st_r == S_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
    if (st_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_r.angle_x <= ang0;
      out_r.angle_y <= ang1;
      out_r.angle_z <= ang2;
      out_r.held_gyro_x <= 16'($signed(gx_r));
      out_r.held_gyro_y <= 16'($signed(gy_r));
      out_r.held_gyro_z <= 16'($signed(gz_r));
      out_r.fresh <= item_fresh_r;
      out_r.undefined_axes <= {u2, u1, u0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      step_r <= '0;
    end else begin
      st_r <= st_nxt;
      step_r <= step_nxt;
    end
  end

  logic unused;
  assign unused = d1 ^ d2;
  assign out_valid = out_valid_r;
  assign out_data = out_r;
endmodule

[rtl/core/ata_checker.sv]
// Port-level checker for the tilt angle unit, bound to the top level.
// Depends on ata_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ata_checker
  import ata_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input ata_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input ata_out_t out_data
);
  `ATA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled beat changed")
  `ATA_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "second beat taken while busy")
  `ATA_ASSERT_IMP(a_range, clk, rst_n, out_valid, !out_data.undefined_axes[0] || out_data.angle_x == 16'sd0, "undefined axis with angle")
  `ATA_ASSERT_IMP(a_und_z, clk, rst_n, out_valid, !out_data.undefined_axes[2] || out_data.angle_z == 16'sd0, "undefined z axis with angle")
endmodule

bind accel_tilt_angle_unit ata_checker u_ata_checker (.*);

[tb/tb.sv]
// Self-checking testbench for accel_tilt_angle_unit: directed table, then random beats.
// Depends on ata_pkg and the unit itself; predicts every result beat in software.
module tb;
  import ata_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ata_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ata_out_t out_data;

  accel_tilt_angle_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  localparam int WatchdogLimit = 20000;
  localparam int NumRandom = 600;

  typedef struct {
    ata_in_t  beat;
    logic     has_exp;
    ata_out_t exp;
  } tilt_row_t;

  ata_out_t  tilt_queue[$];
  int        errors;
  int        accepted_in;
  int        accepted_out;
  int        undef_seen;
  int        idle_cycles;
  logic signed [15:0] held_acc[3];
  logic signed [15:0] held_gyr[3];
  bit        no_idle;
  bit        rx_hold;
  bit        finishing;
  tilt_row_t directed[$];

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint tilt_of(longint n, longint d, output bit undef);
    longint x, y, z, nx, ny, full;
    bit neg;
    longint tab[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
    undef = 1'b0;
    full = 90 << 8;
    if (d == 0) begin
      if (n == 0) begin
        undef = 1'b1;
        return 0;
      end
      return n < 0 ? -full : full;
    end
    neg = (n < 0) != (d < 0);
    x = d < 0 ? -d : d;
    y = n < 0 ? -n : n;
    z = 0;
    for (int i = 0; i < 23; i++) begin
      if (y >= 0) begin
        nx = x + shr_floor(y, i);
        ny = y - shr_floor(x, i);
        z += tab[i];
      end else begin
        nx = x - shr_floor(y, i);
        ny = y + shr_floor(x, i);
        z -= tab[i];
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    if (z > (longint'(90) << 16)) z = longint'(90) << 16;
    z = (z + 128) >>> 8;
    if (n == 0) neg = 1'b0;
    return neg ? -z : z;
  endfunction

  function automatic ata_out_t predict_tilt(ata_in_t b);
    ata_out_t r;
    longint ax, ay, az;
    bit u;
    r = '0;
    r.fresh = (b.status & FreshMask) != 0;
    if (r.fresh) begin
      held_acc = '{b.acc_x, b.acc_y, b.acc_z};
      held_gyr = '{b.gyro_x, b.gyro_y, b.gyro_z};
    end
    ax = held_acc[0];
    ay = held_acc[1];
    az = held_acc[2];
    r.angle_x = 16'(tilt_of(ax * 128, int_sqrt((ay * ay + az * az) << 14), u));
    r.undefined_axes[0] = u;
    r.angle_y = 16'(tilt_of(ay * 128, int_sqrt((ax * ax + az * az) << 14), u));
    r.undefined_axes[1] = u;
    r.angle_z = 16'(tilt_of(int_sqrt((ax * ax + ay * ay) << 14), az * 128, u));
    r.undefined_axes[2] = u;
    r.held_gyro_x = held_gyr[0];
    r.held_gyro_y = held_gyr[1];
    r.held_gyro_z = held_gyr[2];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d",
             accepted_out, what, got, want);
    errors++;
  endtask

  function automatic ata_in_t make_beat(logic [7:0] st, int x, int y, int z);
    ata_in_t b;
    b.status = st;
    b.acc_x = 16'(x);
    b.acc_y = 16'(y);
    b.acc_z = 16'(z);
    b.gyro_x = 16'($urandom);
    b.gyro_y = 16'($urandom);
    b.gyro_z = 16'($urandom);
    return b;
  endfunction

  task automatic add_row(ata_in_t b, bit has, ata_out_t e);
    tilt_row_t row;
    row.beat = b;
    row.has_exp = has;
    row.exp = e;
    directed.push_back(row);
  endtask

  // Offers one beat, holding it steady until it is accepted. Valid drops only
  // while idling, so back-to-back beats keep it high.
  task automatic send_beat(ata_in_t b);
    while (!no_idle && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      tilt_queue.push_back(predict_tilt(in_data));
      accepted_in++;
    end
  end

  // Expected-value override for directed rows whose answer is plain.
  ata_out_t typed_exp[$];
  int       typed_idx[$];

  always @(posedge clk) begin
    ata_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (tilt_queue.size() == 0) begin
        $display("unexpected result beat %0d", accepted_out);
        errors++;
      end else begin
        e = tilt_queue.pop_front();
        if (typed_idx.size() != 0 && typed_idx[0] == accepted_out) begin
          void'(typed_idx.pop_front());
          e = typed_exp.pop_front();
        end
        if (out_data.undefined_axes != 0) undef_seen++;
        if (out_data.angle_x !== e.angle_x)
          report_mismatch("angle_x", out_data.angle_x, e.angle_x);
        if (out_data.angle_y !== e.angle_y)
          report_mismatch("angle_y", out_data.angle_y, e.angle_y);
        if (out_data.angle_z !== e.angle_z)
          report_mismatch("angle_z", out_data.angle_z, e.angle_z);
        if (out_data.held_gyro_x !== e.held_gyro_x)
          report_mismatch("held_gyro_x", out_data.held_gyro_x, e.held_gyro_x);
        if (out_data.held_gyro_y !== e.held_gyro_y)
          report_mismatch("held_gyro_y", out_data.held_gyro_y, e.held_gyro_y);
        if (out_data.held_gyro_z !== e.held_gyro_z)
          report_mismatch("held_gyro_z", out_data.held_gyro_z, e.held_gyro_z);
        if (out_data.fresh !== e.fresh)
          report_mismatch("fresh", out_data.fresh, e.fresh);
        if (out_data.undefined_axes !== e.undefined_axes)
          report_mismatch("undefined_axes", out_data.undefined_axes, e.undefined_axes);
      end
      accepted_out++;
    end
  end

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || finishing || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", tilt_queue.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    ata_out_t e;
    ata_in_t b;
    int sel;
    errors = 0;
    accepted_in = 0;
    accepted_out = 0;
    undef_seen = 0;
    held_acc = '{0, 0, 0};
    held_gyr = '{0, 0, 0};
    no_idle = 0;
    rx_hold = 0;
    finishing = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;

    // After reset with no new samples: zero over zero on every axis.
    e = '0;
    e.undefined_axes = 3'b111;
    b = make_beat(8'hFC, 1234, -55, 7);
    b.gyro_x = 16'sd0;
    b.gyro_y = 16'sd0;
    b.gyro_z = 16'sd0;
    add_row(b, 1, e);
    // Zero vector latched: flags all set, gyro held.
    b = make_beat(8'h01, 0, 0, 0);
    e = '0;
    e.fresh = 1'b1;
    e.undefined_axes = 3'b111;
    e.held_gyro_x = b.gyro_x;
    e.held_gyro_y = b.gyro_y;
    e.held_gyro_z = b.gyro_z;
    add_row(b, 1, e);
    // Pure X axis: +90, 0, and Z denominator zero gives +90.
    b = make_beat(8'h02, 1000, 0, 0);
    e = '0;
    e.fresh = 1'b1;
    e.angle_x = 16'sd23040;
    e.angle_z = 16'sd23040;
    e.held_gyro_x = b.gyro_x;
    e.held_gyro_y = b.gyro_y;
    e.held_gyro_z = b.gyro_z;
    add_row(b, 1, e);
    b = make_beat(8'h03, -32768, 0, 0);
    e.angle_x = -16'sd23040;
    e.held_gyro_x = b.gyro_x;
    e.held_gyro_y = b.gyro_y;
    e.held_gyro_z = b.gyro_z;
    add_row(b, 1, e);
    add_row(make_beat(8'h01, 0, 32767, 0), 0, e);
    add_row(make_beat(8'h01, 0, -32768, 0), 0, e);
    add_row(make_beat(8'h01, 0, 0, 32767), 0, e);
    add_row(make_beat(8'h01, 0, 0, -32768), 0, e);
    add_row(make_beat(8'hFF, 32767, 32767, 32767), 0, e);
    add_row(make_beat(8'h01, -32768, -32768, -32768), 0, e);
    add_row(make_beat(8'h00, 5, 5, 5), 0, e);
    add_row(make_beat(8'hFE, 1, -1, 1), 0, e);
    add_row(make_beat(8'hFD, -1, 1, -1), 0, e);
    add_row(make_beat(8'h80, 0, 0, 0), 0, e);
    add_row(make_beat(8'h01, 16384, 0, 16384), 0, e);
    add_row(make_beat(8'h02, 0, -16384, -16384), 0, e);
    add_row(make_beat(8'h55, 32767, -32768, 1), 0, e);
    b = make_beat(8'h03, 0, 0, 0);
    b.gyro_x = 16'sh7FFF;
    b.gyro_y = -16'sh8000;
    b.gyro_z = 16'sh5555;
    add_row(b, 0, e);
    b.status = 8'hAA;
    b.gyro_x = -16'sh8000;
    b.gyro_y = 16'sh7FFF;
    b.gyro_z = -16'sh5556;
    add_row(b, 0, e);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].has_exp) begin
        typed_idx.push_back(i);
        typed_exp.push_back(directed[i].exp);
      end
      send_beat(directed[i].beat);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 150) no_idle = 1;
      if (n == 250) no_idle = 0;
      if (n == 300) begin
        // Let everything drain before carrying on.
        in_valid <= 1'b0;
        @(posedge clk);
        while (tilt_queue.size() != 0) @(posedge clk);
        fork
          begin
            rx_hold = 1;
            repeat (400) @(posedge clk);
            rx_hold = 0;
          end
        join_none
      end
      sel = $urandom_range(9);
      b.status = 8'($urandom);
      if (sel < 7 && b.status[1:0] == 2'b00) b.status[0] = 1'b1;
      b.gyro_x = 16'($urandom);
      b.gyro_y = 16'($urandom);
      b.gyro_z = 16'($urandom);
      b.acc_x = 16'($urandom);
      b.acc_y = 16'($urandom);
      b.acc_z = 16'($urandom);
      if (sel == 7) begin
        // Realistic: x and y small, z within half of full scale.
        b.acc_x = 16'($signed($urandom_range(4000)) - 2000);
        b.acc_y = 16'($signed($urandom_range(4000)) - 2000);
        b.acc_z = 16'($signed($urandom_range(32767)) - 16384);
      end else if (sel == 8) begin
        if ($urandom_range(1)) b.acc_x = '0;
        if ($urandom_range(1)) b.acc_y = '0;
        if ($urandom_range(1)) b.acc_z = '0;
      end
      send_beat(b);
    end

    in_valid <= 1'b0;
    finishing = 1;
    @(posedge clk);
    while (tilt_queue.size() != 0 || rx_hold) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d input beats and %0d result beats, %0d with undefined axes",
             accepted_in, accepted_out, undef_seen);
    if (errors == 0 && tilt_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, tilt_queue.size());
      $display("FAIL");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ata_pkg.sv
rtl/core/ata_isqrt.sv
rtl/core/ata_cordic_lane.sv
rtl/core/accel_tilt_angle_unit.sv
rtl/core/ata_checker.sv
tb/tb.sv
